>>> sv/scb_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and color tables of the color bar pixel unit
package scb_pkg;

  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned DIM_W          = 13;
  localparam int unsigned STRIDE_W       = 16;
  localparam int unsigned ARGB_W         = 32;
  localparam int unsigned OFS_W          = 28;
  localparam int unsigned APB_ADDR_W     = 4;
  localparam int unsigned APB_DATA_W     = 32;
  localparam int unsigned NUM_STAGES     = 3;

  localparam logic [DIM_W-1:0]    WIDTH_RST  = DIM_W'(640);
  localparam logic [DIM_W-1:0]    HEIGHT_RST = DIM_W'(480);
  localparam logic [STRIDE_W-1:0] STRIDE_RST = STRIDE_W'(2560);

  // floor(n / 7) as (n * RECIP7) >> RECIP7_SHIFT, exact for n below 2**16
  localparam int unsigned RECIP7       = 74899;
  localparam int unsigned RECIP7_W     = 17;
  localparam int unsigned RECIP7_SHIFT = 19;
  localparam int unsigned MUL7_W       = STRIDE_W + RECIP7_W;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_LINE_STRIDE  = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [DIM_W-1:0]    frame_width;
    logic [DIM_W-1:0]    frame_height;
    logic [STRIDE_W-1:0] line_stride;
  } cfg_t;

  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } pipe_ctrl_t;

  function automatic logic [ARGB_W-1:0] argb(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b, input logic [7:0] a);
    return {a, r, g, b};
  endfunction

  function automatic logic [ARGB_W-1:0] top_color(input logic [2:0] idx);
    logic [ARGB_W-1:0] c;
    case (idx)
      3'd0:    c = argb(8'd192, 8'd192, 8'd192, 8'd255);
      3'd1:    c = argb(8'd192, 8'd192, 8'd0,   8'd255);
      3'd2:    c = argb(8'd0,   8'd192, 8'd192, 8'd255);
      3'd3:    c = argb(8'd0,   8'd192, 8'd0,   8'd255);
      3'd4:    c = argb(8'd192, 8'd0,   8'd192, 8'd255);
      3'd5:    c = argb(8'd192, 8'd0,   8'd0,   8'd255);
      default: c = argb(8'd0,   8'd0,   8'd192, 8'd255);
    endcase
    return c;
  endfunction

  function automatic logic [ARGB_W-1:0] mid_color(input logic [2:0] idx);
    logic [ARGB_W-1:0] c;
    case (idx)
      3'd0:    c = argb(8'd0,   8'd0,   8'd192, 8'd127);
      3'd1:    c = argb(8'd19,  8'd19,  8'd19,  8'd127);
      3'd2:    c = argb(8'd192, 8'd0,   8'd192, 8'd127);
      3'd3:    c = argb(8'd19,  8'd19,  8'd19,  8'd127);
      3'd4:    c = argb(8'd0,   8'd192, 8'd192, 8'd127);
      3'd5:    c = argb(8'd19,  8'd19,  8'd19,  8'd127);
      default: c = argb(8'd192, 8'd192, 8'd192, 8'd127);
    endcase
    return c;
  endfunction

  function automatic logic [ARGB_W-1:0] low_color(input logic [2:0] idx);
    logic [ARGB_W-1:0] c;
    case (idx)
      3'd0:    c = argb(8'd0,   8'd33,  8'd76,  8'd255);
      3'd1:    c = argb(8'd255, 8'd255, 8'd255, 8'd255);
      3'd2:    c = argb(8'd50,  8'd0,   8'd106, 8'd255);
      3'd3:    c = argb(8'd19,  8'd19,  8'd19,  8'd255);
      3'd4:    c = argb(8'd9,   8'd9,   8'd9,   8'd255);
      3'd5:    c = argb(8'd19,  8'd19,  8'd19,  8'd255);
      3'd6:    c = argb(8'd29,  8'd29,  8'd29,  8'd255);
      default: c = argb(8'd19,  8'd19,  8'd19,  8'd255);
    endcase
    return c;
  endfunction

endpackage

>>> sv/scb_if.sv
`timescale 1ns / 1ps
// request and result channel interfaces of the color bar pixel unit
interface scb_req_if import scb_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface scb_res_if import scb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ARGB_W-1:0] pixel_argb;
  logic [OFS_W-1:0]  byte_offset;
  logic              inside_frame;

  modport source (output valid, output pixel_argb, output byte_offset, output inside_frame,
                  input ready);
  modport sink   (input valid, input pixel_argb, input byte_offset, input inside_frame,
                  output ready);
endinterface

>>> sv/scb_apb_regs.sv
`timescale 1ns / 1ps
// apb configuration registers of the color bar pixel unit
module scb_apb_regs import scb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  logic [DIM_W-1:0]    width_q, width_d;
  logic [DIM_W-1:0]    height_q, height_d;
  logic [STRIDE_W-1:0] stride_q, stride_d;
  logic                wr_en;
  reg_idx_e            idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[APB_ADDR_W-1:2]);

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    stride_d = stride_q;
    if (wr_en) begin
      case (idx)
        REG_FRAME_WIDTH:  width_d  = pwdata[DIM_W-1:0];
        REG_FRAME_HEIGHT: height_d = pwdata[DIM_W-1:0];
        REG_LINE_STRIDE:  stride_d = pwdata[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FRAME_WIDTH:  prdata = APB_DATA_W'(width_q);
      REG_FRAME_HEIGHT: prdata = APB_DATA_W'(height_q);
      REG_LINE_STRIDE:  prdata = APB_DATA_W'(stride_q);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      stride_q <= STRIDE_RST;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      stride_q <= stride_d;
    end
  end

  assign cfg_o = '{frame_width: width_q, frame_height: height_q, line_stride: stride_q};

endmodule

>>> sv/scb_pipe_ctrl.sv
`timescale 1ns / 1ps
// valid bits and per-stage load enables of the pixel pipeline
module scb_pipe_ctrl import scb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output pipe_ctrl_t ctrl_o
);

  logic [NUM_STAGES-1:0] valid_q, valid_d;
  logic [NUM_STAGES-1:0] rdy;

  always_comb begin
    rdy[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || out_ready_i;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      rdy[i] = !valid_q[i] || rdy[i+1];
    end
  end

  always_comb begin
    valid_d[0] = rdy[0] ? in_valid_i : valid_q[0];
    for (int i = 1; i < NUM_STAGES; i++) begin
      valid_d[i] = rdy[i] ? valid_q[i-1] : valid_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = valid_q[NUM_STAGES-1];
  assign ctrl_o.load = rdy;

endmodule

>>> sv/scb_datapath.sv
`timescale 1ns / 1ps
// three-stage datapath: geometry products, bar splits and offset, color select
module scb_datapath import scb_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  pipe_ctrl_t            ctrl_i,
  input  cfg_t                  cfg_i,
  input  logic [COORD_BITS-1:0] pixel_x_i,
  input  logic [COORD_BITS-1:0] pixel_y_i,
  output logic [ARGB_W-1:0]     pixel_argb_o,
  output logic [OFS_W-1:0]      byte_offset_o,
  output logic                  inside_frame_o
);

  localparam int unsigned CMP_W     = ((COORD_BITS > DIM_W) ? COORD_BITS : DIM_W) + 4;
  localparam int unsigned PROD_W    = COORD_BITS + STRIDE_W;
  localparam int unsigned OFS_SUM_W = (PROD_W + 1 > OFS_W) ? PROD_W + 1 : OFS_W;

  // stage 0
  logic [COORD_BITS-1:0] x0_q;
  logic                  in0_q, in0_d;
  logic                  top0_q, top0_d;
  logic                  mid0_q, mid0_d;
  logic [PROD_W-1:0]     prod0_q, prod0_d;
  logic [MUL7_W-1:0]     m5_q, m5_d;
  logic [MUL7_W-1:0]     m6_q, m6_d;
  logic [MUL7_W-1:0]     m1_q, m1_d;
  logic [CMP_W-1:0]      w_ext, h_ext, xi_ext, yi_ext, y9, h6, h7;
  logic [STRIDE_W-1:0]   w5, w6;

  // stage 1
  logic [COORD_BITS-1:0] x1_q;
  logic                  in1_q, top1_q, mid1_q;
  logic [OFS_W-1:0]      ofs1_q, ofs1_d;
  logic [DIM_W-1:0]      split5_q, split6_q, narrow_q;
  logic [2:0]            tidx1_q, tidx1_d;
  logic [CMP_W-1:0]      x0_ext, x7;
  logic [OFS_SUM_W-1:0]  ofs_sum;

  // stage 2
  logic [ARGB_W-1:0]     argb_q, argb_d;
  logic [OFS_W-1:0]      ofs2_q;
  logic                  in2_q;
  logic [CMP_W-1:0]      x1_ext, x4, s5, s6, nw, dx, d3;
  logic                  lt5, lt6;
  logic [2:0]            lidx, nidx;
  logic [ARGB_W-1:0]     color;

  assign w_ext  = CMP_W'(cfg_i.frame_width);
  assign h_ext  = CMP_W'(cfg_i.frame_height);
  assign xi_ext = CMP_W'(pixel_x_i);
  assign yi_ext = CMP_W'(pixel_y_i);
  assign y9     = (yi_ext << 3) + yi_ext + CMP_W'(9);
  assign h6     = (h_ext << 2) + (h_ext << 1);
  assign h7     = (h_ext << 3) - h_ext;
  assign w5     = (STRIDE_W'(cfg_i.frame_width) << 2) + STRIDE_W'(cfg_i.frame_width);
  assign w6     = (STRIDE_W'(cfg_i.frame_width) << 2) + (STRIDE_W'(cfg_i.frame_width) << 1);

  always_comb begin
    in0_d   = (xi_ext < w_ext) && (yi_ext < h_ext);
    top0_d  = y9 <= h6;
    mid0_d  = y9 <= h7;
    prod0_d = PROD_W'(pixel_y_i) * PROD_W'(cfg_i.line_stride);
    m5_d    = MUL7_W'(w5) * MUL7_W'(RECIP7);
    m6_d    = MUL7_W'(w6) * MUL7_W'(RECIP7);
    m1_d    = MUL7_W'(cfg_i.frame_width) * MUL7_W'(RECIP7);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[0]) begin
      x0_q    <= pixel_x_i;
      in0_q   <= in0_d;
      top0_q  <= top0_d;
      mid0_q  <= mid0_d;
      prod0_q <= prod0_d;
      m5_q    <= m5_d;
      m6_q    <= m6_d;
      m1_q    <= m1_d;
    end
  end

  assign x0_ext  = CMP_W'(x0_q);
  assign x7      = (x0_ext << 3) - x0_ext;
  assign ofs_sum = OFS_SUM_W'(prod0_q) + (OFS_SUM_W'(x0_q) << 2);
  assign ofs1_d  = ofs_sum[OFS_W-1:0];

  always_comb begin
    tidx1_d = 3'd0;
    for (int k = 1; k <= 6; k++) begin
      if (x7 >= CMP_W'(k) * w_ext) begin
        tidx1_d = tidx1_d + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[1]) begin
      x1_q     <= x0_q;
      in1_q    <= in0_q;
      top1_q   <= top0_q;
      mid1_q   <= mid0_q;
      ofs1_q   <= ofs1_d;
      tidx1_q  <= tidx1_d;
      split5_q <= m5_q[RECIP7_SHIFT +: DIM_W];
      split6_q <= m6_q[RECIP7_SHIFT +: DIM_W];
      narrow_q <= m1_q[RECIP7_SHIFT +: DIM_W];
    end
  end

  assign x1_ext = CMP_W'(x1_q);
  assign x4     = x1_ext << 2;
  assign s5     = CMP_W'(split5_q);
  assign s6     = CMP_W'(split6_q);
  assign nw     = CMP_W'(narrow_q);
  assign lt5    = x1_ext < s5;
  assign lt6    = x1_ext < s6;
  assign dx     = x1_ext - s5;
  assign d3     = (dx << 1) + dx;

  always_comb begin
    lidx = 3'd0;
    nidx = 3'd4;
    for (int k = 1; k <= 3; k++) begin
      if (x4 >= CMP_W'(k) * s5) begin
        lidx = lidx + 3'd1;
      end
      if (d3 >= CMP_W'(k) * nw) begin
        nidx = nidx + 3'd1;
      end
    end
  end

  always_comb begin
    if (top1_q) begin
      color = top_color(tidx1_q);
    end else if (mid1_q) begin
      color = mid_color(tidx1_q);
    end else if (lt5) begin
      color = low_color(lidx);
    end else if (lt6) begin
      color = low_color(nidx);
    end else begin
      color = low_color(3'd7);
    end
    argb_d = in1_q ? color : '0;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[2]) begin
      argb_q <= argb_d;
      ofs2_q <= ofs1_q;
      in2_q  <= in1_q;
    end
  end

  assign pixel_argb_o   = argb_q;
  assign byte_offset_o  = ofs2_q;
  assign inside_frame_o = in2_q;

endmodule

>>> sv/smpte_color_bar_pixel_unit.sv
`timescale 1ns / 1ps
// color bar pixel unit top level: pixel coordinate in, argb color and byte offset out
//
//   channel   dir   handshake          payload
//   req_i     in    valid / ready      pixel_x, pixel_y
//   res_o     out   valid / ready      pixel_argb, byte_offset, inside_frame
//   apb       in    psel / penable     frame_width, frame_height, line_stride
//
// one request per cycle unless a stall at res_o holds stage 0; a result is registered in each stage in turn
// the three stages are multiply, split and offset, then compare and color select
// a stall at res_o holds each full stage whose later stages are all full; others keep filling
// reset clears the valid bits and loads 640 x 480 with a 2560 byte stride
module smpte_color_bar_pixel_unit import scb_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  scb_req_if.sink               req_i,
  scb_res_if.source             res_o
);

  cfg_t       cfg;
  pipe_ctrl_t ctrl;

  scb_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  scb_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .ctrl_o      (ctrl)
  );

  scb_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .ctrl_i         (ctrl),
    .cfg_i          (cfg),
    .pixel_x_i      (req_i.pixel_x),
    .pixel_y_i      (req_i.pixel_y),
    .pixel_argb_o   (res_o.pixel_argb),
    .byte_offset_o  (res_o.byte_offset),
    .inside_frame_o (res_o.inside_frame)
  );

endmodule

>>> sv/scb_checker.sv
`timescale 1ns / 1ps
// port-level checks of the color bar pixel unit and their binding
module scb_checker import scb_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              req_valid_i,
  input logic              req_ready_i,
  input logic              res_valid_i,
  input logic              res_ready_i,
  input logic [ARGB_W-1:0] pixel_argb_i,
  input logic [OFS_W-1:0]  byte_offset_i,
  input logic              inside_frame_i
);

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(pixel_argb_i)
      && $stable(byte_offset_i) && $stable(inside_frame_i))
    else $error("result changed while stalled");

  a_outside_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !inside_frame_i |-> pixel_argb_i == '0)
    else $error("outside pixel is not zero");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_valid_i |-> req_ready_i)
    else $error("request refused with empty output");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i) ##1 res_ready_i ##1 res_ready_i |=> res_valid_i)
    else $error("result missing three cycles after request");

endmodule

bind smpte_color_bar_pixel_unit scb_checker u_scb_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .res_valid_i    (res_o.valid),
  .res_ready_i    (res_o.ready),
  .pixel_argb_i   (res_o.pixel_argb),
  .byte_offset_i  (res_o.byte_offset),
  .inside_frame_i (res_o.inside_frame)
);

>>> verif/scb_result_check.sv
`timescale 1ns / 1ps
// result checker of the color bar pixel unit: predicts every pixel request and compares in order
module scb_result_check import scb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  scb_req_if                    req_i,
  scb_res_if                    res_i,
  output int unsigned           pending_o,
  output int unsigned           fail_cnt_o
);

  typedef struct packed {
    logic [COORD_BITS_DEF-1:0] x;
    logic [COORD_BITS_DEF-1:0] y;
    logic [ARGB_W-1:0]         argb;
    logic [OFS_W-1:0]          offset;
    logic                      in_frame;
  } pixel_t;

  localparam logic [ARGB_W-1:0] TOP_BARS [0:6] = '{
    32'hFFC0C0C0, 32'hFFC0C000, 32'hFF00C0C0, 32'hFF00C000,
    32'hFFC000C0, 32'hFFC00000, 32'hFF0000C0
  };
  localparam logic [ARGB_W-1:0] MID_BARS [0:6] = '{
    32'h7F0000C0, 32'h7F131313, 32'h7FC000C0, 32'h7F131313,
    32'h7F00C0C0, 32'h7F131313, 32'h7FC0C0C0
  };
  localparam logic [ARGB_W-1:0] LOW_BARS [0:7] = '{
    32'hFF00214C, 32'hFFFFFFFF, 32'hFF32006A, 32'hFF131313,
    32'hFF090909, 32'hFF131313, 32'hFF1D1D1D, 32'hFF131313
  };

  pixel_t      pending_pixels [$];
  int unsigned frame_w;
  int unsigned frame_h;
  int unsigned stride;

  function automatic pixel_t smpte_pixel(input logic [COORD_BITS_DEF-1:0] x,
                                         input logic [COORD_BITS_DEF-1:0] y,
                                         input int unsigned w, input int unsigned h,
                                         input int unsigned line_bytes);
    pixel_t      p;
    int unsigned xi;
    int unsigned yi;
    int unsigned split5;
    int unsigned split6;
    int unsigned narrow;
    int unsigned idx;
    longint unsigned ofs;
    xi         = x;
    yi         = y;
    p.x        = x;
    p.y        = y;
    ofs        = longint'(yi) * longint'(line_bytes) + 4 * longint'(xi);
    p.offset   = ofs[OFS_W-1:0];
    p.in_frame = (xi < w) && (yi < h);
    p.argb     = '0;
    if (p.in_frame) begin
      split5 = w * 5 / 7;
      split6 = w * 6 / 7;
      narrow = w / 7;
      if (yi < h * 6 / 9) begin
        idx    = xi * 7 / w;
        p.argb = TOP_BARS[(idx < 7) ? idx : 6];
      end else if (yi < h * 7 / 9) begin
        idx    = xi * 7 / w;
        p.argb = MID_BARS[(idx < 7) ? idx : 6];
      end else if (xi < split5) begin
        idx    = xi * 4 / split5;
        p.argb = LOW_BARS[idx & 7];
      end else if (xi < split6 && narrow != 0) begin
        idx    = (xi - split5) * 3 / narrow + 4;
        p.argb = LOW_BARS[(idx < 8) ? idx : 7];
      end else begin
        p.argb = LOW_BARS[7];
      end
    end
    return p;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t      exp_pix;
    int unsigned fails;
    if (!rst_ni) begin
      pending_pixels.delete();
      frame_w    = WIDTH_RST;
      frame_h    = HEIGHT_RST;
      stride     = STRIDE_RST;
      pending_o  <= 0;
      fail_cnt_o <= 0;
    end else begin
      fails = 0;
      if (res_i.valid && res_i.ready) begin
        if (pending_pixels.size() == 0) begin
          $display("%0t: result with none expected: argb %h offset %h inside %b", $time,
                   res_i.pixel_argb, res_i.byte_offset, res_i.inside_frame);
          fails++;
        end else begin
          exp_pix = pending_pixels.pop_front();
          if (res_i.pixel_argb !== exp_pix.argb) begin
            $display("%0t: pixel (%0d,%0d) pixel_argb expected %h got %h", $time,
                     exp_pix.x, exp_pix.y, exp_pix.argb, res_i.pixel_argb);
            fails++;
          end
          if (res_i.byte_offset !== exp_pix.offset) begin
            $display("%0t: pixel (%0d,%0d) byte_offset expected %h got %h", $time,
                     exp_pix.x, exp_pix.y, exp_pix.offset, res_i.byte_offset);
            fails++;
          end
          if (res_i.inside_frame !== exp_pix.in_frame) begin
            $display("%0t: pixel (%0d,%0d) inside_frame expected %b got %b", $time,
                     exp_pix.x, exp_pix.y, exp_pix.in_frame, res_i.inside_frame);
            fails++;
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        pending_pixels.push_back(smpte_pixel(req_i.pixel_x, req_i.pixel_y,
                                             frame_w, frame_h, stride));
      end
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[3:2]))
          REG_FRAME_WIDTH:  frame_w = pwdata[DIM_W-1:0];
          REG_FRAME_HEIGHT: frame_h = pwdata[DIM_W-1:0];
          REG_LINE_STRIDE:  stride  = pwdata[STRIDE_W-1:0];
          default: begin
          end
        endcase
      end
      pending_o  <= pending_pixels.size();
      fail_cnt_o <= fail_cnt_o + fails;
    end
  end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// testbench top of the color bar pixel unit: clock, reset, register writes, requests and verdict
module tb_top;
  import scb_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned NUM_DIRECTED  = 24;
  localparam int unsigned NUM_SETTINGS  = 9;
  localparam int unsigned NUM_FIXED     = 7;
  localparam int unsigned ITEMS_PER_SET = 70;

  localparam int unsigned DIR_X [0:NUM_DIRECTED-1] = '{
    0, 639, 640, 0, 0, 4095, 639, 0, 0, 0, 0, 456,
    457, 547, 548, 0, 114, 115, 229, 343, 91, 92, 2730, 1365
  };
  localparam int unsigned DIR_Y [0:NUM_DIRECTED-1] = '{
    0, 0, 0, 479, 480, 4095, 479, 319, 320, 372, 373, 400,
    400, 400, 400, 400, 400, 400, 400, 400, 100, 100, 1365, 2730
  };

  localparam cfg_t FRAME_SETTINGS [0:NUM_FIXED-1] = '{
    '{13'd7,    13'd1,    16'd28},
    '{13'd4096, 13'd4096, 16'd65535},
    '{13'd6,    13'd10,   16'd0},
    '{13'd0,    13'd0,    16'd1000},
    '{13'd8191, 13'd8191, 16'd65535},
    '{13'd13,   13'd9,    16'd52},
    '{13'd1920, 13'd1080, 16'd7680}
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  int unsigned           pending_cnt;
  int unsigned           fail_cnt;
  int unsigned           send_idle_pct;
  int unsigned           recv_idle_pct;
  int unsigned           cycle_cnt;

  scb_req_if req ();
  scb_res_if res ();

  smpte_color_bar_pixel_unit DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req_i   (req),
    .res_o   (res)
  );

  scb_result_check u_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .req_i      (req),
    .res_i      (res),
    .pending_o  (pending_cnt),
    .fail_cnt_o (fail_cnt)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      res.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_pixel(input logic [COORD_BITS_DEF-1:0] x,
                            input logic [COORD_BITS_DEF-1:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid   <= 1'b1;
    req.pixel_x <= x;
    req.pixel_y <= y;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
  endtask

  // hold requests until every result is back, then let the pipeline settle
  task automatic drain_pixels();
    req.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (NUM_STAGES + 2) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // mostly in or just past the frame, some on band and bar edges, some anywhere
  function automatic logic [COORD_BITS_DEF-1:0] pick_coord(input int dim, input int b1,
                                                          input int b2, input int b3);
    int c;
    int hi;
    hi = (dim > 4095) ? 4095 : dim;
    case ($urandom_range(9))
      0, 1: c = int'($urandom_range(4095));
      2, 3: begin
        case ($urandom_range(5))
          0:       c = b1 - 1 + int'($urandom_range(1));
          1:       c = b2 - 1 + int'($urandom_range(1));
          2:       c = b3 - 1 + int'($urandom_range(1));
          3:       c = dim - 1 + int'($urandom_range(1));
          4:       c = int'($urandom_range(1));
          default: c = hi - int'($urandom_range(1));
        endcase
      end
      default: c = int'($urandom_range(hi));
    endcase
    if (c < 0) c = 0;
    if (c > 4095) c = 4095;
    return c[COORD_BITS_DEF-1:0];
  endfunction

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("%0t: run did not finish in time", $time);
    $display("** smpte_color_bar_pixel_unit: FAILED **");
    $finish;
  end

  initial begin
    cfg_t        cfg;
    int unsigned rnd_cnt;
    int          w;
    int          h;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    req.valid     = 1'b0;
    req.pixel_x   = '0;
    req.pixel_y   = '0;
    res.ready     = 1'b0;
    send_idle_pct = 21;
    recv_idle_pct = 67;
    rnd_cnt       = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default 640 x 480 frame: corners, points past the frame, band and bar edges
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_pixel(DIR_X[i][COORD_BITS_DEF-1:0], DIR_Y[i][COORD_BITS_DEF-1:0]);
    end

    for (int s = 0; s < NUM_SETTINGS; s++) begin
      if (s < NUM_FIXED) begin
        cfg = FRAME_SETTINGS[s];
      end else begin
        cfg.frame_width  = DIM_W'($urandom_range(7, 4096));
        cfg.frame_height = DIM_W'($urandom_range(1, 4096));
        cfg.line_stride  = STRIDE_W'($urandom_range(28, 65535));
      end
      drain_pixels();
      write_reg(REG_FRAME_WIDTH, APB_DATA_W'(cfg.frame_width));
      write_reg(REG_FRAME_HEIGHT, APB_DATA_W'(cfg.frame_height));
      write_reg(REG_LINE_STRIDE, APB_DATA_W'(cfg.line_stride));
      w = int'(cfg.frame_width);
      h = int'(cfg.frame_height);
      for (int n = 0; n < ITEMS_PER_SET; n++) begin
        if (rnd_cnt < 210) begin
          send_idle_pct = 21;
          recv_idle_pct = 67;
        end else if (rnd_cnt < 420) begin
          send_idle_pct = 67;
          recv_idle_pct = 21;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        send_pixel(pick_coord(w, w * 5 / 7, w * 6 / 7, w / 7),
                   pick_coord(h, h * 6 / 9, h * 7 / 9, h / 2));
        rnd_cnt++;
      end
    end

    drain_pixels();
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("** smpte_color_bar_pixel_unit: PASSED **");
    end else begin
      $display("** smpte_color_bar_pixel_unit: FAILED **");
    end
    $finish;
  end

endmodule
